// ===== rtl/signed_int_to_decimal_chars_unit_macros.svh =====
`ifndef SIGNED_INT_TO_DECIMAL_CHARS_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_CHARS_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SIDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SIDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sidc_pkg.sv =====
package sidc_pkg;

    localparam int MAG_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int DD_STEPS   = 8;
    localparam int DD_STAGES  = MAG_W / DD_STEPS;
    localparam int CHAR_W     = 7;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [MAG_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
    } pipe_t;

    // eight shift-add-3 steps of binary to BCD conversion
    function automatic pipe_t dd_step8(pipe_t d);
        pipe_t      r;
        logic [3:0] dig;
        r = d;
        for (int s = 0; s < DD_STEPS; s++)
        begin
            for (int k = 0; k < BCD_DIGITS; k++)
            begin
                dig = r.bcd[k*4 +: 4];
                if (dig >= 4'd5)
                begin
                    r.bcd[k*4 +: 4] = dig + 4'd3;
                end
            end
            r.bcd = {r.bcd[BCD_W-2:0], r.bin[MAG_W-1]};
            r.bin = {r.bin[MAG_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/sidc_dd_stage.sv =====
module sidc_dd_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  sidc_pkg::pipe_t d,
    output sidc_pkg::pipe_t q
);
    import sidc_pkg::*;

    pipe_t q_reg;
    pipe_t q_next;

    always_comb
    begin
        q_next = advance ? dd_step8(d) : q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/sidc_emit.sv =====
module sidc_emit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sidc_pkg::pipe_t              p,
    output logic                         take,
    output logic [sidc_pkg::CHAR_W-1:0]  char_code,
    output logic                         last_char,
    output logic                         char_valid,
    input  logic                         char_stall
);
    import sidc_pkg::*;

    logic              busy_reg,   busy_next;
    logic              minus_reg,  minus_next;
    logic [3:0]        idx_reg,    idx_next;
    logic [BCD_W-1:0]  bcd_reg,    bcd_next;
    logic              oval_reg,   oval_next;
    logic [CHAR_W-1:0] ochar_reg,  ochar_next;
    logic              olast_reg,  olast_next;
    logic              out_free;
    logic [3:0]        hi;
    logic [3:0]        digit;

    // index of the most significant nonzero digit, zero if none
    always_comb
    begin
        hi = '0;
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (p.bcd[k*4 +: 4] != 4'd0)
            begin
                hi = 4'(k);
            end
        end
    end

    always_comb
    begin
        out_free   = !oval_reg || !char_stall;
        take       = !busy_reg;
        digit      = bcd_reg[idx_reg*4 +: 4];
        busy_next  = busy_reg;
        minus_next = minus_reg;
        idx_next   = idx_reg;
        bcd_next   = bcd_reg;
        oval_next  = oval_reg;
        ochar_next = ochar_reg;
        olast_next = olast_reg;
        if (busy_reg && out_free)
        begin
            oval_next = 1'b1;
            if (minus_reg)
            begin
                ochar_next = ASCII_MINUS;
                olast_next = 1'b0;
                minus_next = 1'b0;
            end
            else
            begin
                ochar_next = ASCII_ZERO + {3'b000, digit};
                olast_next = (idx_reg == 4'd0);
                if (idx_reg == 4'd0)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg - 4'd1;
                end
            end
        end
        else if (out_free)
        begin
            oval_next = 1'b0;
        end
        if (take && p.valid)
        begin
            busy_next  = 1'b1;
            minus_next = p.neg;
            bcd_next   = p.bcd;
            idx_next   = hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        minus_reg <= minus_next;
        idx_reg   <= idx_next;
        bcd_reg   <= bcd_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    assign char_code  = ochar_reg;
    assign last_char  = olast_reg;
    assign char_valid = oval_reg;

endmodule

// ===== rtl/signed_int_to_decimal_chars_unit.sv =====
// channel  | valid       | stall       | payload
// value    | value_valid | value_stall | value[31:0] signed
// char     | char_valid  | char_stall  | char_code[6:0], last_char
//
// Input register plus four binary-to-BCD stages of eight steps each; a word
// can enter every cycle while the character emitter has room.
// The emitter sends one character a cycle unless char stalls; a number has
// 1 to 11 characters, and the emitter takes the next word only once the last
// character of the word is in its output register. Reset clears all valid
// bits; a stall on char holds the emitter, and the pipe stops while its last
// stage holds a word that the emitter cannot take.
module signed_int_to_decimal_chars_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [31:0]           value,
    input  logic                         value_valid,
    output logic                         value_stall,
    output logic [sidc_pkg::CHAR_W-1:0]  char_code,
    output logic                         last_char,
    output logic                         char_valid,
    input  logic                         char_stall
);
    import sidc_pkg::*;

    pipe_t      in_reg, in_next;
    pipe_t      stage_q [DD_STAGES+1];
    logic       advance;
    logic       take;
    logic [MAG_W-1:0] raw;

    always_comb
    begin
        advance       = !stage_q[DD_STAGES].valid || take;
        value_stall   = !advance;
        raw           = MAG_W'(value);
        in_next       = in_reg;
        if (advance)
        begin
            in_next.valid = value_valid;
            in_next.neg   = raw[MAG_W-1];
            in_next.bin   = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;
            in_next.bcd   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg <= '0;
        end
        else
        begin
            in_reg <= in_next;
        end
    end

    assign stage_q[0] = in_reg;

    for (genvar g = 0; g < DD_STAGES; g++)
    begin : g_dd
        sidc_dd_stage u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .d       (stage_q[g]),
            .q       (stage_q[g+1])
        );
    end

    sidc_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .p          (stage_q[DD_STAGES]),
        .take       (take),
        .char_code  (char_code),
        .last_char  (last_char),
        .char_valid (char_valid),
        .char_stall (char_stall)
    );

endmodule

// ===== rtl/sidc_checker.sv =====
`include "signed_int_to_decimal_chars_unit_macros.svh"

module sidc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic signed [31:0]           value,
    input logic                         value_valid,
    input logic                         value_stall,
    input logic [sidc_pkg::CHAR_W-1:0]  char_code,
    input logic                         last_char,
    input logic                         char_valid,
    input logic                         char_stall
);
    import sidc_pkg::*;

    logic is_minus;
    logic is_digit;

    assign is_minus = (char_code == ASCII_MINUS);
    assign is_digit = (char_code >= ASCII_ZERO) && (char_code <= (ASCII_ZERO + 7'd9));

    `SIDC_ASSERT_NEXT(a_in_hold, value_valid && value_stall,
        value_valid && $stable(value), "stalled input word changed")
    `SIDC_ASSERT_NEXT(a_hold, char_valid && char_stall,
        char_valid && $stable(char_code) && $stable(last_char), "stalled char changed")
    `SIDC_ASSERT_NOW(a_code, char_valid, is_minus || is_digit, "bad char code")
    `SIDC_ASSERT_NOW(a_minus_last, char_valid && is_minus, !last_char, "minus flagged last")
    `SIDC_ASSERT_NEXT(a_minus_once, char_valid && !char_stall && is_minus,
        !(char_valid && is_minus), "two minus signs in a row")

endmodule

bind signed_int_to_decimal_chars_unit sidc_checker u_chk (.*);

// ===== tb/sidc_char_monitor.sv =====
module sidc_char_monitor
    import sidc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] value,
    input  logic               value_valid,
    input  logic               value_stall,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic               last_char,
    input  logic               char_valid,
    input  logic               char_stall,
    output int                 mismatch_count,
    output int                 chars_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } dec_char_t;

    dec_char_t expected_text[$];

    // decimal text of one word, sign first, most significant digit first
    task automatic push_decimal_text(input logic [31:0] v);
        logic [31:0] mag;
        logic [3:0]  digits[10];
        int          nd;
        int          k;
        dec_char_t   c;
        mag = v[31] ? (32'd0 - v) : v;
        nd = 0;
        do
        begin
            digits[nd] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            nd++;
        end
        while (mag != 32'd0);
        if (v[31])
        begin
            c.code = ASCII_MINUS;
            c.is_last = 1'b0;
            expected_text.push_back(c);
        end
        for (k = nd - 1; k >= 0; k--)
        begin
            c.code = ASCII_ZERO + CHAR_W'(digits[k]);
            c.is_last = (k == 0);
            expected_text.push_back(c);
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        chars_pending = 0;
    end

    always @(posedge clk)
    begin
        dec_char_t want;
        if (rst_n)
        begin
            if (value_valid && !value_stall)
            begin
                push_decimal_text(value);
            end
            if (char_valid && !char_stall)
            begin
                if (expected_text.size() == 0)
                begin
                    $display("%0t: unexpected char: code %0d last %0b",
                             $time, char_code, last_char);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (char_code !== want.code)
                    begin
                        $display("%0t: char_code mismatch: expected %0d, got %0d",
                                 $time, want.code, char_code);
                        mismatch_count++;
                    end
                    if (last_char !== want.is_last)
                    begin
                        $display("%0t: last_char mismatch: expected %0b, got %0b",
                                 $time, want.is_last, last_char);
                        mismatch_count++;
                    end
                end
            end
            chars_pending = expected_text.size();
        end
    end

endmodule

// ===== tb/signed_int_to_decimal_chars_unit_tb.sv =====
module signed_int_to_decimal_chars_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STUCK_LIMIT = 3000;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 20;

    logic                          clk;
    logic                          rst_n;
    logic signed [31:0]            value;
    logic                          value_valid;
    logic                          value_stall;
    logic [sidc_pkg::CHAR_W-1:0]   char_code;
    logic                          last_char;
    logic                          char_valid;
    logic                          char_stall;

    int mismatch_count;
    int chars_pending;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    int stuck_cycles;

    logic [31:0] corner_values[16] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, 32'd99, 32'd100,
        -32'sd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
        32'd1000000000, -32'sd1000000000, 32'd999999999, 32'd1234567890
    };

    signed_int_to_decimal_chars_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .value_valid(value_valid),
        .value_stall(value_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .char_valid (char_valid),
        .char_stall (char_stall)
    );

    sidc_char_monitor u_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .value         (value),
        .value_valid   (value_valid),
        .value_stall   (value_stall),
        .char_code     (char_code),
        .last_char     (last_char),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .mismatch_count(mismatch_count),
        .chars_pending (chars_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // receiver: random stall, or a long hold-off on request
    initial
    begin
        char_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    char_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            char_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (value_valid && !value_stall) || (char_valid && !char_stall))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic logic [31:0] random_value();
        logic [31:0] mag;
        longint      span;
        int          nd;
        case ($urandom_range(0, 3))
            0: mag = $urandom;
            1: mag = $urandom_range(0, 99);
            2:
            begin
                nd = $urandom_range(1, 10);
                span = 1;
                repeat (nd) span = span * 10;
                mag = 32'(longint'($urandom) % span);
            end
            default:
            begin
                mag = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
                return mag;
            end
        endcase
        return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
    endfunction

    // called at a falling edge, returns at a falling edge after acceptance
    task automatic send_word(input logic [31:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            value_valid <= 1'b0;
            @(negedge clk);
        end
        value <= v;
        value_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (value_stall);
        @(negedge clk);
    endtask

    task automatic wait_all_chars();
        value_valid <= 1'b0;
        @(negedge clk);
        while (chars_pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        value = '0;
        value_valid = 1'b0;
        hold_req = 1'b0;
        send_idle_pct = 12;
        recv_stall_pct = 57;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (corner_values[i])
        begin
            send_word(corner_values[i]);
        end
        for (int i = 0; i < 38; i++)
        begin
            if (i == 10)
            begin
                hold_req = 1'b1;
            end
            send_word(random_value());
        end
        wait_all_chars();

        send_idle_pct = 57;
        recv_stall_pct = 12;
        for (int i = 0; i < 53; i++)
        begin
            if (i == 25)
            begin
                wait_all_chars();
            end
            send_word(random_value());
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 53; i++)
        begin
            send_word(random_value());
        end

        wait_all_chars();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && chars_pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
